>>> hdl/grouped_min_max_mean_aggregator_top_macros.svh
// ---------------------------------------------------------------------------
// Aggregator assertion macros
// Concurrent check wrappers, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef GROUPED_MIN_MAX_MEAN_AGGREGATOR_TOP_MACROS_SVH
`define GROUPED_MIN_MAX_MEAN_AGGREGATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GMA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define GMA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define GMA_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define GMA_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

>>> hdl/gmma_pkg.sv
// ---------------------------------------------------------------------------
// Aggregator package
// Widths, status codes, FSM states, the key record and the cell match record.
// ---------------------------------------------------------------------------
package gmma_pkg;
	localparam int TableEntries = 64;
	localparam int SensorCount  = 6;
	localparam int ValueBits    = 32;
	localparam int IdxW         = 6;
	localparam int UsedW        = 7;
	localparam int SumW         = 56;
	localparam int CntW         = 32;
	localparam int SlotW        = 9;
	localparam logic [11:0] StartYearRst  = 12'd2024;
	localparam logic [3:0]  StartMonthRst = 4'd3;

	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_NEW      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_FILTERED = 3'd3;
	localparam logic [2:0] ST_UNUSED   = 3'd4;
	localparam logic [2:0] ST_READ     = 3'd5;

	localparam logic CFG_START_YEAR  = 1'b0;
	localparam logic CFG_START_MONTH = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_UPD_RD, S_UPD_WAIT, S_UPD_WR, S_ADD_OUT,
		S_RD_RD, S_RD_WAIT, S_DIV, S_RD_OUT, S_ONE_OUT
	} state_t;

	typedef struct packed {
		logic [15:0] dev;
		logic [11:0] yr;
		logic [3:0]  mo;
	} key_t;

	// what one cell reports to the sequencer
	typedef struct packed {
		logic hit;
		logic [IdxW-1:0] idx;
	} match_t;
endpackage

>>> hdl/gmma_key_cell.sv
// ---------------------------------------------------------------------------
// Key cell
// Holds one entry's key; passes the probe key and the first hit rightward.
// ---------------------------------------------------------------------------
module gmma_key_cell
	import gmma_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IdxW-1:0]  my_idx,
	input  logic             wr,
	input  key_t             wr_key,
	input  logic             used,
	input  key_t             probe_in,
	input  match_t           match_in,
	output key_t             probe_out,
	output match_t           match_out,
	output key_t             key_out
);
	key_t key_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			key_q <= wr_key;
		end
		probe_out <= probe_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_out <= '0;
		end else if (match_in.hit) begin
			match_out <= match_in;
		end else begin
			match_out.hit <= used && (key_q == probe_in);
			match_out.idx <= my_idx;
		end
	end

	assign key_out = key_q;
endmodule

>>> hdl/gmma_divider.sv
// ---------------------------------------------------------------------------
// Mean divider
// Signed 56 / 32 restoring divider, one quotient bit a cycle, clamped.
// ---------------------------------------------------------------------------
module gmma_divider
	import gmma_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [SumW-1:0] dividend,
	input  logic [CntW-1:0]        divisor,
	output logic                   done,
	output logic [ValueBits-1:0]   quotient
);
	logic [SumW-1:0] q_q;
	logic [CntW:0]   rem_q;
	logic [CntW-1:0] dvs_q;
	logic            neg_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic [CntW:0]   trial;
	logic [CntW:0]   shifted;
	logic signed [SumW:0] sq;
	localparam logic [SumW:0] QMax = {{(SumW-ValueBits+1){1'b0}}, {(ValueBits-1){1'b1}}};

	assign shifted = {rem_q[CntW-1:0], q_q[SumW-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(SumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend[SumW-1] ? SumW'(-dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[SumW-1];
		end else if (busy_q) begin
			if (!trial[CntW]) begin
				rem_q <= trial;
				q_q   <= {q_q[SumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[SumW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
		if (dvs_q == '0) begin
			quotient = '0;
		end else if (!sq[SumW] && (sq > $signed(QMax))) begin
			quotient = {1'b0, {(ValueBits-1){1'b1}}};
		end else if (sq[SumW] && (sq < -$signed(QMax) - 1)) begin
			quotient = {1'b1, {(ValueBits-1){1'b0}}};
		end else begin
			quotient = sq[ValueBits-1:0];
		end
	end
endmodule

>>> hdl/grouped_min_max_mean_aggregator_top.sv
// ---------------------------------------------------------------------------
// Grouped min/max/mean aggregator
// Key table in a chain of 64 key cells, statistics in one-port memories.
// ---------------------------------------------------------------------------
// Add item: key search (probe crosses 64 cells, match registered), then per
//   sensor read, wait and write of the statistics (write only for a new entry);
//   a filtered or full item gets its result without the update.
// Read item: per sensor read, check, serial divide, output; an unused index
//   gives a single result. Input stalls until back in idle.
// Reset clears entries_used, the start-date registers and control; stores are unwritten.
`include "grouped_min_max_mean_aggregator_top_macros.svh"
module grouped_min_max_mean_aggregator_top
	import gmma_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] device_id,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic signed [31:0] value_0,
	input  logic signed [31:0] value_1,
	input  logic signed [31:0] value_2,
	input  logic signed [31:0] value_3,
	input  logic signed [31:0] value_4,
	input  logic signed [31:0] value_5,
	input  logic [5:0]  read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  entry_index,
	output logic [15:0] key_device,
	output logic [11:0] key_year,
	output logic [3:0]  key_month,
	output logic [2:0]  sensor_index,
	output logic signed [31:0] max_value,
	output logic signed [31:0] min_value,
	output logic signed [55:0] value_sum,
	output logic [31:0] sample_count,
	output logic signed [31:0] mean_value,
	output logic        last
);
	localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
	localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

	logic [11:0] start_year_q;
	logic [3:0]  start_month_q;
	logic [UsedW-1:0] used_q;
	state_t state_q, state_d;

	// latched item
	logic        mode_q;
	key_t        key_q;
	logic [ValueBits-1:0] val_q [SensorCount];
	logic [IdxW-1:0] ridx_q;
	logic [IdxW-1:0] ent_q;
	logic [2:0]  sen_q;
	logic [6:0]  tick_q;
	logic        isnew_q;

	// stat memories (one row per entry*sensor; counts one row per entry)
	logic [ValueBits-1:0] max_mem [TableEntries*SensorCount];
	logic [ValueBits-1:0] min_mem [TableEntries*SensorCount];
	logic [SumW-1:0]      sum_mem [TableEntries*SensorCount];
	logic [CntW-1:0]      cnt_mem [TableEntries];
	logic [ValueBits-1:0] max_rd_q, min_rd_q;
	logic [SumW-1:0]      sum_rd_q;
	logic [CntW-1:0]      cnt_rd_q;
	logic [SlotW-1:0]     slot;

	// output register
	logic        ov_q;
	logic [2:0]  st_q;
	logic [5:0]  ei_q;
	key_t        ok_q;
	logic [2:0]  si_q;
	logic [31:0] mx_q, mn_q, mean_q, cn_q;
	logic [55:0] sm_q;
	logic        last_q;

	// key cell chain
	key_t   probe [TableEntries+1];
	match_t mt    [TableEntries+1];
	key_t   keys  [TableEntries];
	match_t res_q;

	logic accept, pass_date;
	logic div_start, div_done;
	logic [ValueBits-1:0] quo;
	logic signed [ValueBits-1:0] v;
	logic signed [SumW-1:0] sum_new, sv;
	logic [ValueBits-1:0] mx_new, mn_new;
	logic load_out, out_free;

	assign slot = SlotW'(ent_q * SensorCount + sen_q);
	assign accept = in_valid && !in_stall;
	assign out_free = !ov_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign pass_date = (key_q.yr > start_year_q) ||
		(key_q.yr == start_year_q && key_q.mo >= start_month_q);

	assign probe[0] = key_q;
	assign mt[0] = '0;
	for (genvar g = 0; g < TableEntries; g++) begin : g_cell
		gmma_key_cell u_cell (
			.clk(clk), .arst_n(arst_n), .my_idx(IdxW'(g)),
			.wr(state_q == S_ADD_OUT && isnew_q && ent_q == IdxW'(g)),
			.wr_key(key_q), .used(UsedW'(g) < used_q),
			.probe_in(probe[g]), .match_in(mt[g]),
			.probe_out(probe[g+1]), .match_out(mt[g+1]), .key_out(keys[g])
		);
	end

	gmma_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sum_rd_q), .divisor(cnt_rd_q), .done(div_done), .quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_year_q  <= StartYearRst;
			start_month_q <= StartMonthRst;
		end else if (cfg_we) begin
			if (cfg_index == CFG_START_YEAR) start_year_q <= cfg_data;
			else start_month_q <= cfg_data[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: if (accept) state_d = in_valid && mode ? S_RD_RD : S_SEARCH;
			S_SEARCH: begin
				if (mode_q && {1'b0, ridx_q} >= used_q) begin
					if (out_free) begin load_out = 1'b1; state_d = S_IDLE; end
				end else if (mode_q) begin
					state_d = S_RD_WAIT;
				end else if (!pass_date) begin
					if (out_free) begin load_out = 1'b1; state_d = S_IDLE; end
				end else if (tick_q == 7'(TableEntries+1)) begin
					if (res_q.hit) state_d = S_UPD_RD;
					else if (used_q == UsedW'(TableEntries)) begin
						if (out_free) begin load_out = 1'b1; state_d = S_IDLE; end
					end else state_d = S_UPD_WR;
				end
			end
			S_UPD_RD:   state_d = S_UPD_WAIT;
			S_UPD_WAIT: state_d = S_UPD_WR;
			S_UPD_WR: begin
				if (sen_q == 3'(SensorCount-1)) state_d = S_ADD_OUT;
				else state_d = isnew_q ? S_UPD_WR : S_UPD_RD;
			end
			S_ADD_OUT: if (out_free) begin load_out = 1'b1; state_d = S_IDLE; end
			S_RD_RD: state_d = S_SEARCH;
			S_RD_WAIT: begin div_start = 1'b1; state_d = S_DIV; end
			S_DIV: if (div_done) state_d = S_RD_OUT;
			S_RD_OUT: if (out_free) begin
				load_out = 1'b1;
				state_d = (sen_q == 3'(SensorCount-1)) ? S_IDLE : S_RD_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// item latch and sequencing counters
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= '{dev: device_id, yr: year, mo: month};
			val_q[0] <= value_0; val_q[1] <= value_1; val_q[2] <= value_2;
			val_q[3] <= value_3; val_q[4] <= value_4; val_q[5] <= value_5;
			ridx_q <= read_index;
			ent_q  <= read_index;
			sen_q  <= '0;
			tick_q <= '0;
		end else begin
			if (state_q == S_SEARCH && !mode_q) begin
				if (tick_q != 7'(TableEntries+1)) tick_q <= tick_q + 7'd1;
				if (tick_q == 7'(TableEntries+1)) begin
					isnew_q <= !res_q.hit;
					ent_q <= res_q.hit ? res_q.idx : used_q[IdxW-1:0];
				end
			end
			if (state_q == S_UPD_WR && sen_q != 3'(SensorCount-1)) sen_q <= sen_q + 3'd1;
			if (state_q == S_RD_OUT && out_free) sen_q <= sen_q + 3'd1;
		end
		// match taken once the probe has left the last cell
		if (tick_q == 7'(TableEntries)) res_q <= mt[TableEntries];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) used_q <= '0;
		else if (state_q == S_ADD_OUT && out_free && isnew_q) used_q <= used_q + 1'b1;
	end

	// statistic update
	always_comb begin
		v = $signed(val_q[sen_q]);
		sv = $signed(sum_rd_q);
		if (v > 0 && sv > SumMax - SumW'(v)) sum_new = SumMax;
		else if (v < 0 && sv < SumMin - SumW'(v)) sum_new = SumMin;
		else sum_new = sv + SumW'(v);
		mx_new = (v > $signed(max_rd_q)) ? val_q[sen_q] : max_rd_q;
		mn_new = (v < $signed(min_rd_q)) ? val_q[sen_q] : min_rd_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD_RD || state_q == S_RD_RD || state_q == S_RD_OUT ||
		    state_q == S_SEARCH) begin
			max_rd_q <= max_mem[slot];
			min_rd_q <= min_mem[slot];
			sum_rd_q <= sum_mem[slot];
			cnt_rd_q <= cnt_mem[ent_q];
		end
		if (state_q == S_UPD_WR) begin
			if (isnew_q) begin
				max_mem[slot] <= val_q[sen_q];
				min_mem[slot] <= val_q[sen_q];
				sum_mem[slot] <= SumW'($signed(val_q[sen_q]));
				cnt_mem[ent_q] <= 32'd1;
			end else begin
				max_mem[slot] <= mx_new;
				min_mem[slot] <= mn_new;
				sum_mem[slot] <= sum_new;
				if (sen_q == '0 && cnt_rd_q != '1) cnt_mem[ent_q] <= cnt_rd_q + 32'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (load_out) ov_q <= 1'b1;
		else if (!out_stall) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			st_q <= ST_UPDATED; ei_q <= '0; ok_q <= '0; si_q <= '0;
			mx_q <= '0; mn_q <= '0; sm_q <= '0; cn_q <= '0; mean_q <= '0;
			last_q <= 1'b1;
			case (state_q)
				S_SEARCH: begin
					if (mode_q) begin st_q <= ST_UNUSED; ei_q <= ridx_q; end
					else if (!pass_date) st_q <= ST_FILTERED;
					else st_q <= ST_FULL;
				end
				S_ADD_OUT: begin
					st_q <= isnew_q ? ST_NEW : ST_UPDATED;
					ei_q <= ent_q;
					ok_q <= isnew_q ? key_q : keys[ent_q];
				end
				S_RD_OUT: begin
					st_q <= ST_READ; ei_q <= ent_q; ok_q <= keys[ent_q]; si_q <= sen_q;
					mx_q <= max_rd_q; mn_q <= min_rd_q; sm_q <= sum_rd_q;
					cn_q <= cnt_rd_q; mean_q <= quo;
					last_q <= (sen_q == 3'(SensorCount-1));
				end
				default: st_q <= ST_UPDATED;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign status = st_q;
	assign entry_index = ei_q;
	assign key_device = ok_q.dev;
	assign key_year = ok_q.yr;
	assign key_month = ok_q.mo;
	assign sensor_index = si_q;
	assign max_value = mx_q;
	assign min_value = mn_q;
	assign value_sum = sm_q;
	assign sample_count = cn_q;
	assign mean_value = mean_q;
	assign last = last_q;

	`GMA_ASSERT_IMP(a_stall_busy, clk, arst_n, state_q != S_IDLE, in_stall, "busy but not stalled")
	`GMA_ASSERT_IMP(a_used_max, clk, arst_n, 1'b1, used_q <= UsedW'(TableEntries), "table overrun")
	`GMA_ASSERT_NXT(a_out_hold, clk, arst_n, ov_q && out_stall, ov_q && $stable(st_q), "result lost")
endmodule
